@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define SWHS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SWHS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/swhs_pkg.sv @@
package swhs_pkg;

    localparam int MAX_WALLS = 64;
    localparam int COORD_W   = 24;
    localparam int SLOT_W    = 6;
    localparam int WIDX_W    = $clog2(MAX_WALLS);
    localparam int CNT_W     = 7;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int S_TDATA_W = ((SLOT_W + 4 * COORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((1 + SLOT_W + 7) / 8) * 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Sign tests per wall: query line vs wall ends, wall line vs query ends.
    localparam logic [1:0] STEP_QW0 = 2'd0;
    localparam logic [1:0] STEP_QW1 = 2'd1;
    localparam logic [1:0] STEP_WQ0 = 2'd2;
    localparam logic [1:0] STEP_WQ1 = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] ez;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] sz;
        logic signed [COORD_W-1:0] sx;
    } t_seg;

    typedef struct packed {
        logic       issue;
        logic [1:0] step;
    } t_cross_ctl;

    typedef struct packed {
        logic       valid;
        logic [1:0] step;
        logic       neg;
        logic       zero;
    } t_cross_res;

endpackage

@@ hw/rtl/swhs_wall_mem.sv @@
module swhs_wall_mem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [swhs_pkg::WIDX_W-1:0] i_waddr,
    input  swhs_pkg::t_seg              i_wdata,
    input  logic [swhs_pkg::WIDX_W-1:0] i_raddr,
    output swhs_pkg::t_seg              o_rdata
);
    import swhs_pkg::*;

    t_seg r_mem [MAX_WALLS];
    t_seg r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/swhs_cross_unit.sv @@
module swhs_cross_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swhs_pkg::t_seg       i_query,
    input  swhs_pkg::t_seg       i_wall,
    input  swhs_pkg::t_cross_ctl i_ctl,
    output swhs_pkg::t_cross_res o_res
);
    import swhs_pkg::*;

    t_seg                      base;
    t_seg                      tip;
    logic signed [COORD_W-1:0] pt_x;
    logic signed [COORD_W-1:0] pt_z;
    logic signed [DIFF_W-1:0]  n_ax, n_az, n_bx, n_bz;
    logic signed [DIFF_W-1:0]  r_ax, r_az, r_bx, r_bz;
    logic signed [PROD_W-1:0]  r_p, r_q;
    logic signed [PROD_W:0]    diff;
    logic                      r_v1, r_v2, r_v3;
    logic [1:0]                r_k1, r_k2, r_k3;
    logic                      r_neg, r_zero;

    always_comb begin
        if (i_ctl.step == STEP_QW0 || i_ctl.step == STEP_QW1) begin
            base = i_query;
        end else begin
            base = i_wall;
        end
        tip = base;
        unique case (i_ctl.step)
            STEP_QW0: begin
                pt_x = i_wall.sx;
                pt_z = i_wall.sz;
            end
            STEP_QW1: begin
                pt_x = i_wall.ex;
                pt_z = i_wall.ez;
            end
            STEP_WQ0: begin
                pt_x = i_query.sx;
                pt_z = i_query.sz;
            end
            default: begin
                pt_x = i_query.ex;
                pt_z = i_query.ez;
            end
        endcase
        n_ax = {tip.ex[COORD_W-1], tip.ex} - {base.sx[COORD_W-1], base.sx};
        n_az = {tip.ez[COORD_W-1], tip.ez} - {base.sz[COORD_W-1], base.sz};
        n_bx = {pt_x[COORD_W-1], pt_x} - {base.sx[COORD_W-1], base.sx};
        n_bz = {pt_z[COORD_W-1], pt_z} - {base.sz[COORD_W-1], base.sz};
    end

    assign diff = {r_p[PROD_W-1], r_p} - {r_q[PROD_W-1], r_q};

    // Differences, then products, then sign of ax*bz - az*bx.
    always_ff @(posedge i_clk) begin
        r_ax   <= n_ax;
        r_az   <= n_az;
        r_bx   <= n_bx;
        r_bz   <= n_bz;
        r_p    <= r_ax * r_bz;
        r_q    <= r_az * r_bx;
        r_neg  <= diff[PROD_W];
        r_zero <= (diff == '0);
        r_k1   <= i_ctl.step;
        r_k2   <= r_k1;
        r_k3   <= r_k2;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_res.valid = r_v3;
    assign o_res.step  = r_k3;
    assign o_res.neg   = r_neg;
    assign o_res.zero  = r_zero;

endmodule

@@ hw/rtl/segment_wall_hit_search.sv @@
// Wall crossing search. A request on the slave side with tuser = 0 writes
// one wall into the 64-entry table and completes with no result. A request
// with tuser = 1 scans walls 0 .. min(wall_count, 64) - 1 in order and
// returns one result: hit and the index of the first wall that the
// movement segment strictly crosses. The single cross-product unit (two
// 25x25 multipliers, three stages) evaluates the four sign tests of each
// wall one after another, and the scan stops on a hit. The slave side is
// not ready while a query runs. A finished result waits in the output
// register while the next request is taken; a query that finishes while
// that result is still waiting stays busy until it is taken.
// wall_count is written through the cfg channel; the user must write it
// only while the block is idle, the block itself does not enforce this.
module segment_wall_hit_search (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [swhs_pkg::CNT_W-1:0]     i_cfg_data,   // wall_count
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // slot, start_x, start_z, end_x, end_z, zero pad
    input  logic [swhs_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tuser,    // operation
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // hit, wall_index, zero pad
    output logic [swhs_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import swhs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;
    localparam logic [2:0] PH_LAST = 3'd7;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_wall_cnt;
    logic [CNT_W-1:0]  r_lim;
    logic [CNT_W-1:0]  r_idx;
    logic [2:0]        r_ph;
    logic [3:0]        r_neg, r_zero;
    logic              r_hit;
    t_seg              r_query;
    t_seg              in_seg;
    t_seg              wall;
    logic [SLOT_W-1:0] in_slot;
    logic              s_acc, wr_en, wall_cross, out_free;
    logic              r_m_valid, r_m_hit;
    logic [SLOT_W-1:0] r_m_idx;
    t_cross_ctl        ctl;
    t_cross_res        res;

    assign in_slot   = i_s_tdata[SLOT_W-1:0];
    assign in_seg.sx = i_s_tdata[SLOT_W + COORD_W - 1 : SLOT_W];
    assign in_seg.sz = i_s_tdata[SLOT_W + 2*COORD_W - 1 : SLOT_W + COORD_W];
    assign in_seg.ex = i_s_tdata[SLOT_W + 3*COORD_W - 1 : SLOT_W + 2*COORD_W];
    assign in_seg.ez = i_s_tdata[SLOT_W + 4*COORD_W - 1 : SLOT_W + 3*COORD_W];

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign wr_en       = s_acc && (i_s_tuser == OP_WRITE)
                         && (CNT_W'(in_slot) < CNT_W'(MAX_WALLS));
    assign out_free    = !r_m_valid || i_m_tready;

    assign ctl.issue = (r_state == ST_RUN) && !r_ph[2];
    assign ctl.step  = r_ph[1:0];

    assign wall_cross = !r_zero[STEP_QW0] && !r_zero[STEP_QW1]
                        && (r_neg[STEP_QW0] != r_neg[STEP_QW1])
                        && !r_zero[STEP_WQ0] && !r_zero[STEP_WQ1]
                        && (r_neg[STEP_WQ0] != r_neg[STEP_WQ1]);

    swhs_wall_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (in_slot[WIDX_W-1:0]),
        .i_wdata (in_seg),
        .i_raddr (r_idx[WIDX_W-1:0]),
        .o_rdata (wall)
    );

    swhs_cross_unit u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_query (r_query),
        .i_wall  (wall),
        .i_ctl   (ctl),
        .o_res   (res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc && i_s_tuser == OP_QUERY) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = (r_idx == r_lim) ? ST_DONE : ST_RUN;
            end
            ST_RUN: begin
                if (r_ph == PH_LAST) begin
                    n_state = wall_cross ? ST_DONE : ST_READ;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_query <= in_seg;
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_lim   <= (r_wall_cnt > CNT_W'(MAX_WALLS)) ? CNT_W'(MAX_WALLS) : r_wall_cnt;
        end
        if (r_state == ST_READ) begin
            r_ph <= '0;
        end else begin
            r_ph <= r_ph + 3'd1;
        end
        if (res.valid) begin
            r_neg[res.step]  <= res.neg;
            r_zero[res.step] <= res.zero;
        end
        if (r_state == ST_RUN && r_ph == PH_LAST) begin
            if (wall_cross) begin
                r_hit <= 1'b1;
            end else begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
        if (r_state == ST_DONE && out_free) begin
            r_m_hit <= r_hit;
            r_m_idx <= r_hit ? r_idx[SLOT_W-1:0] : '0;
        end
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wall_cnt <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_wall_cnt <= i_cfg_data;
            end
            if (r_state == ST_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {(M_TDATA_W - 1 - SLOT_W)'(0), r_m_idx, r_m_hit};

endmodule

@@ hw/rtl/swhs_checker.sv @@
`include "assert_macros.svh"

module swhs_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [swhs_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import swhs_pkg::*;

    `SWHS_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "stalled result changed")
    `SWHS_ASSERT(a_miss_index, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[SLOT_W:1] == '0, "miss with nonzero index")
    `SWHS_ASSERT(a_query_busy, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tuser == OP_QUERY |=> !o_s_tready, "ready during query")
    `SWHS_ASSERT(a_write_silent, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tuser == OP_WRITE && !o_m_tvalid |=> !o_m_tvalid, "write produced result")

endmodule

bind segment_wall_hit_search swhs_checker u_swhs_checker (.*);
